// ===== rtl/jglc_pkg.sv =====
// shared types, constants and register codes for the joystick gesture lamp control
package jglc_pkg;

  // animation table size and derived widths
  localparam int unsigned MaxAnims = 8;
  localparam int unsigned AnimW    = $clog2(MaxAnims);
  localparam int unsigned AnimCntW = 4;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEngage     = 3'd0,
    CfgRelease    = 3'd1,
    CfgLongPress  = 3'd2,
    CfgAnimCount  = 3'd3,
    CfgIntStep    = 3'd4,
    CfgHueStep    = 3'd5
  } cfg_idx_e;

  // reset values of the configuration registers
  localparam logic [11:0]         EngageRst    = 12'd1434;
  localparam logic [11:0]         ReleaseRst   = 12'd614;
  localparam logic [15:0]         LongPressRst = 16'd500;
  localparam logic [AnimCntW-1:0] AnimCountRst = 4'd4;
  localparam logic [15:0]         IntStepRst   = 16'd66;
  localparam logic [15:0]         HueStepRst   = 16'd18;

  // lamp state reset
  localparam logic [15:0] LevelRst = 16'd32768;

  // queue between classifier and lamp engine
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic signed [11:0] stick_x;
    logic signed [11:0] stick_y;
    logic        [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic        quick_press;
    logic        hold_event;
    logic        gesture_axis;
    logic        direction;
    logic [31:0] hold_delta_ms;
    logic        lamp_on;
    logic [2:0]  anim_index;
    logic [15:0] intensity;
    logic [15:0] hue;
  } out_item_t;

  typedef struct packed {
    logic [11:0]         engage_level;
    logic [11:0]         release_level;
    logic [15:0]         long_press_ms;
    logic [AnimCntW-1:0] anim_count;
    logic [15:0]         intensity_step;
    logic [15:0]         hue_step;
  } cfg_t;

  // classified gesture of one sample
  typedef struct packed {
    logic        quick_press;
    logic        hold_event;
    logic        axis;
    logic        dir;
    logic [31:0] delta_ms;
  } gesture_t;

endpackage

// ===== rtl/jglc_front.sv =====
// gesture classifier: engage, release, short press and hold detection per sample
module jglc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  jglc_pkg::in_item_t    in_data_i,
  output logic                  in_ready_o,
  input  jglc_pkg::cfg_t        cfg_i,
  output logic                  gest_valid_o,
  output jglc_pkg::gesture_t    gest_o,
  input  logic                  gest_ready_i
);

  logic        engaged_q, engaged_d;
  logic        long_q, long_d;
  logic        axis_q, axis_d;
  logic        dir_q, dir_d;
  logic [31:0] start_q, start_d;
  logic [31:0] last_q, last_d;

  logic        accept;
  logic [11:0] mag_x, mag_y, mag_v;
  logic        out_x, out_y;
  logic signed [11:0] eng_v;
  logic [31:0] now, elapsed, past_thr;
  logic        is_long;
  jglc_pkg::gesture_t gest;

  assign accept       = in_valid_i && gest_ready_i;
  assign in_ready_o   = gest_ready_i;
  assign gest_valid_o = in_valid_i;
  assign gest_o       = gest;

  assign now   = in_data_i.time_ms;
  assign mag_x = in_data_i.stick_x[11] ? 12'(-in_data_i.stick_x) : 12'(in_data_i.stick_x);
  assign mag_y = in_data_i.stick_y[11] ? 12'(-in_data_i.stick_y) : 12'(in_data_i.stick_y);
  assign out_x = mag_x >= cfg_i.engage_level;
  assign out_y = mag_y >= cfg_i.engage_level;
  assign eng_v = out_x ? in_data_i.stick_x : in_data_i.stick_y;

  assign mag_v    = axis_q ? mag_y : mag_x;
  assign elapsed  = now - start_q;
  assign is_long  = elapsed >= {16'd0, cfg_i.long_press_ms};
  // first hold step is measured from the threshold moment
  assign past_thr = elapsed - {16'd0, cfg_i.long_press_ms};

  always_comb begin
    engaged_d = engaged_q;
    long_d    = long_q;
    axis_d    = axis_q;
    dir_d     = dir_q;
    start_d   = start_q;
    last_d    = last_q;
    gest      = '0;
    if (!engaged_q) begin
      if (out_x != out_y) begin
        engaged_d = 1'b1;
        long_d    = 1'b0;
        axis_d    = !out_x;
        dir_d     = !eng_v[11] && (eng_v != 12'sd0);
        start_d   = now;
      end
    end else if (mag_v < cfg_i.release_level) begin
      engaged_d = 1'b0;
      if (!is_long) begin
        gest.quick_press = 1'b1;
        gest.axis        = axis_q;
        gest.dir         = dir_q;
      end
    end else if (is_long) begin
      long_d          = 1'b1;
      gest.hold_event = 1'b1;
      gest.axis       = axis_q;
      gest.dir        = dir_q;
      gest.delta_ms   = long_q ? (now - last_q) : past_thr;
      last_d          = now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      engaged_q <= 1'b0;
      long_q    <= 1'b0;
      axis_q    <= 1'b0;
      dir_q     <= 1'b0;
      start_q   <= '0;
      last_q    <= '0;
    end else if (accept) begin
      engaged_q <= engaged_d;
      long_q    <= long_d;
      axis_q    <= axis_d;
      dir_q     <= dir_d;
      start_q   <= start_d;
      last_q    <= last_d;
    end
  end

  property p_hold_needs_engaged;
    @(posedge clk_i) disable iff (!rst_ni)
      (accept && gest.hold_event) |-> engaged_q;
  endproperty
  a_hold_needs_engaged: assert property (p_hold_needs_engaged)
    else $error("hold step without engagement");

  property p_release_clears;
    @(posedge clk_i) disable iff (!rst_ni)
      (accept && gest.quick_press) |=> !engaged_q;
  endproperty
  a_release_clears: assert property (p_release_clears)
    else $error("short press left gesture engaged");

  property p_hold_sets_long;
    @(posedge clk_i) disable iff (!rst_ni)
      (accept && gest.hold_event) |=> (long_q && last_q == $past(now));
  endproperty
  a_hold_sets_long: assert property (p_hold_sets_long)
    else $error("hold step did not update hold timing");

endmodule

// ===== rtl/jglc_fifo.sv =====
// short gesture queue between classifier and lamp engine
module jglc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  jglc_pkg::gesture_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output jglc_pkg::gesture_t data_o
);

  jglc_pkg::gesture_t          mem_q [jglc_pkg::QDepth];
  logic [jglc_pkg::QPtrW-1:0]  wr_q, rd_q;
  logic [jglc_pkg::QCntW-1:0]  cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = cnt_q == jglc_pkg::QCntW'(jglc_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == jglc_pkg::QPtrW'(jglc_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == jglc_pkg::QPtrW'(jglc_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/jglc_lamp.sv =====
// lamp engine: product stage, then power, animation, intensity and hue update
module jglc_lamp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                gest_valid_i,
  input  jglc_pkg::gesture_t  gest_i,
  output logic                gest_pop_o,
  input  jglc_pkg::cfg_t      cfg_i,
  output logic                out_valid_o,
  output jglc_pkg::out_item_t out_data_o,
  input  logic                out_ready_i
);

  localparam int unsigned AW = jglc_pkg::AnimW;

  // remainder of a small value by the animation count, restoring steps
  function automatic logic [AW-1:0] mod_cnt(input logic [AW:0] v, input logic [AW:0] c);
    logic [AW:0] r;
    r = '0;
    for (int i = AW; i >= 0; i--) begin
      r = {r[AW-1:0], v[i]};
      if (r >= c) begin
        r = r - c;
      end
    end
    return r[AW-1:0];
  endfunction

  typedef struct packed {
    jglc_pkg::gesture_t g;
    logic [47:0]        int_prod;
    logic [15:0]        hue_prod;
  } stage_t;

  logic   adv;
  logic   s1_valid_q;
  stage_t s1_q;
  logic   out_valid_q;
  jglc_pkg::out_item_t out_q;

  logic          power_q, power_d;
  logic [AW-1:0] sel_q, sel_d, sel_new;
  logic [15:0]   level_q, level_d;
  logic [15:0]   hue_cur_q, hue_cur_d;
  logic [15:0]   hue_tab_q [jglc_pkg::MaxAnims];
  logic          tab_we;
  logic [AW:0]   cnt_eff, step, sum;
  logic [16:0]   inc_sum;

  assign adv         = !out_valid_q || out_ready_i;
  assign gest_pop_o  = adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    if (cfg_i.anim_count == '0) begin
      cnt_eff = (AW+1)'(1);
    end else if (32'(cfg_i.anim_count) > jglc_pkg::MaxAnims) begin
      cnt_eff = (AW+1)'(jglc_pkg::MaxAnims);
    end else begin
      cnt_eff = (AW+1)'(cfg_i.anim_count);
    end
  end

  assign step    = s1_q.g.dir ? (AW+1)'(1) : cnt_eff - 1'b1;
  assign sum     = {1'b0, sel_q} + step;
  assign sel_new = mod_cnt(sum, cnt_eff);
  assign inc_sum = {1'b0, level_q} + {1'b0, s1_q.int_prod[15:0]};

  always_comb begin
    power_d   = power_q;
    sel_d     = sel_q;
    level_d   = level_q;
    hue_cur_d = hue_cur_q;
    tab_we    = 1'b0;
    if (s1_q.g.quick_press && s1_q.g.axis) begin
      power_d = !power_q;
    end else if (power_q) begin
      if (s1_q.g.quick_press) begin
        sel_d     = sel_new;
        hue_cur_d = hue_tab_q[sel_new];
      end else if (s1_q.g.hold_event && s1_q.g.axis) begin
        if (s1_q.g.dir) begin
          if (s1_q.int_prod[47:16] != '0 || inc_sum[16]) begin
            level_d = 16'hFFFF;
          end else begin
            level_d = inc_sum[15:0];
          end
        end else if (s1_q.int_prod[47:16] != '0 || s1_q.int_prod[15:0] >= level_q) begin
          level_d = '0;
        end else begin
          level_d = level_q - s1_q.int_prod[15:0];
        end
      end else if (s1_q.g.hold_event) begin
        tab_we    = 1'b1;
        hue_cur_d = s1_q.g.dir ? hue_cur_q + s1_q.hue_prod : hue_cur_q - s1_q.hue_prod;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      power_q     <= 1'b0;
      sel_q       <= '0;
      level_q     <= jglc_pkg::LevelRst;
      hue_cur_q   <= '0;
      for (int i = 0; i < jglc_pkg::MaxAnims; i++) begin
        hue_tab_q[i] <= '0;
      end
    end else if (adv) begin
      s1_valid_q  <= gest_valid_i;
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        power_q   <= power_d;
        sel_q     <= sel_d;
        level_q   <= level_d;
        hue_cur_q <= hue_cur_d;
        if (tab_we) begin
          hue_tab_q[sel_q] <= hue_cur_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.g        <= gest_i;
      s1_q.int_prod <= {16'd0, gest_i.delta_ms} * {32'd0, cfg_i.intensity_step};
      s1_q.hue_prod <= gest_i.delta_ms[15:0] * cfg_i.hue_step;
      out_q.quick_press   <= s1_q.g.quick_press;
      out_q.hold_event    <= s1_q.g.hold_event;
      out_q.gesture_axis  <= s1_q.g.axis;
      out_q.direction     <= s1_q.g.dir;
      out_q.hold_delta_ms <= s1_q.g.delta_ms;
      out_q.lamp_on       <= power_d;
      out_q.anim_index    <= 3'(sel_d);
      out_q.intensity     <= level_d;
      out_q.hue           <= hue_cur_d;
    end
  end

  property p_hue_mirror;
    @(posedge clk_i) disable iff (!rst_ni)
      hue_cur_q == hue_tab_q[sel_q];
  endproperty
  a_hue_mirror: assert property (p_hue_mirror)
    else $error("current hue out of step with hue table");

  property p_off_level_kept;
    @(posedge clk_i) disable iff (!rst_ni)
      (adv && s1_valid_q && !power_q) |=> $stable(level_q);
  endproperty
  a_off_level_kept: assert property (p_off_level_kept)
    else $error("intensity changed while lamp off");

  property p_one_gesture;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_q |-> !(out_q.quick_press && out_q.hold_event);
  endproperty
  a_one_gesture: assert property (p_one_gesture)
    else $error("short press and hold step in one item");

  property p_delta_only_on_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !out_q.hold_event) |-> (out_q.hold_delta_ms == '0);
  endproperty
  a_delta_only_on_hold: assert property (p_delta_only_on_hold)
    else $error("hold delta reported without hold step");

endmodule

// ===== rtl/joystick_gesture_lamp_control_core.sv =====
// top level of the joystick gesture lamp control: config registers and the two halves
// One joystick sample per item goes in and exactly one lamp status item comes out, in
// order. Items are taken at one per clock while the queue has room: the classifier on
// the input side decides engage, release, short press and hold in the accepting cycle
// and drops a gesture into a two-entry queue; the lamp engine behind it forms the
// intensity and hue products in one stage and updates power, animation, intensity and
// hue in the next, whose result sits in the output register. A stall on the output side
// fills the queue and then drops in_ready_o; the configuration port is always ready and
// must be written by the user only while the block is idle; the block does not enforce
// this. No clearing pass follows reset.
module joystick_gesture_lamp_control_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // sample items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  jglc_pkg::in_item_t                  in_data_i,
  // status items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output jglc_pkg::out_item_t                 out_data_o,
  // register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jglc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [jglc_pkg::CfgDataW-1:0]       cfg_data_i
);

  jglc_pkg::cfg_t     cfg_q;
  jglc_pkg::gesture_t front_gest, q_gest;
  logic               front_valid, q_full, q_valid, q_pop;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.engage_level   <= jglc_pkg::EngageRst;
      cfg_q.release_level  <= jglc_pkg::ReleaseRst;
      cfg_q.long_press_ms  <= jglc_pkg::LongPressRst;
      cfg_q.anim_count     <= jglc_pkg::AnimCountRst;
      cfg_q.intensity_step <= jglc_pkg::IntStepRst;
      cfg_q.hue_step       <= jglc_pkg::HueStepRst;
    end else if (cfg_valid_i) begin
      case (jglc_pkg::cfg_idx_e'(cfg_idx_i))
        jglc_pkg::CfgEngage:    cfg_q.engage_level   <= cfg_data_i[11:0];
        jglc_pkg::CfgRelease:   cfg_q.release_level  <= cfg_data_i[11:0];
        jglc_pkg::CfgLongPress: cfg_q.long_press_ms  <= cfg_data_i;
        jglc_pkg::CfgAnimCount: cfg_q.anim_count     <= cfg_data_i[jglc_pkg::AnimCntW-1:0];
        jglc_pkg::CfgIntStep:   cfg_q.intensity_step <= cfg_data_i;
        jglc_pkg::CfgHueStep:   cfg_q.hue_step       <= cfg_data_i;
        default: begin
          // unmapped index, write dropped
        end
      endcase
    end
  end

  // classifier: one sample per cycle while the queue has room
  jglc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_ready_o   (in_ready_o),
    .cfg_i        (cfg_q),
    .gest_valid_o (front_valid),
    .gest_o       (front_gest),
    .gest_ready_i (!q_full)
  );

  // gesture queue decouples the two halves
  jglc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_gest),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_gest)
  );

  // lamp engine with output register
  jglc_lamp u_lamp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gest_valid_i (q_valid),
    .gest_i       (q_gest),
    .gest_pop_o   (q_pop),
    .cfg_i        (cfg_q),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o),
    .out_ready_i  (out_ready_i)
  );

endmodule
